// ===== rtl/core/brs_pkg.sv =====
// Package for the bilinear RGB image scaler: register indexes, fixed field
// widths and the control sequencer state type. Depends on nothing.
package brs_pkg;

	localparam int CFG_SRC_W = 9;
	localparam int CFG_DST_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam int OUT_IDX_W = 10;
	localparam int TARGET_MAX = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_DIVX, S_DIVY, S_MUL, S_LOC, S_BASE,
		S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_BL1, S_BL2, S_OUT
	} state_t;

endpackage

// ===== rtl/core/brs_ifs.sv =====
// Channel interfaces of the bilinear RGB image scaler: request, pixel result
// and configuration write. Depends on brs_pkg.
interface brs_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
	modport sink (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface brs_out_if;
	logic valid;
	logic ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] pad_byte;
	logic last_pixel;
	modport source (output valid, red_out, green_out, blue_out, pad_byte, last_pixel,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, pad_byte, last_pixel,
		output ready);
endinterface

interface brs_cfg_if;
	logic valid;
	logic ready;
	logic [brs_pkg::CFG_IDX_W-1:0] index;
	logic [brs_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bilinear_rgb_image_scaler.sv =====
// Top level of the bilinear RGB image scaler: frame store, sequencer and blend.
// Depends on brs_pkg, brs_ifs and brs_div.
//
// Usage. Configuration writes arrive on cfg, which is always ready; register
// 0 to 3 are source width, source height, target width and target height.
// Each beat on in_ch carries req_type. A load beat (req_type 0) writes one RGB
// source pixel into the frame store in raster order; in_ch stays ready, so
// loads can follow back to back. An emit beat (req_type 1) produces the next
// pixel of the resized image on out_ch, with a zero pad byte and last_pixel
// set on the final pixel. The emit passes through a locate and a row-base
// state, four reads from the frame store, a state that takes the last read
// data, two blend multiply stages and the output state. in_ch opens again
// when the output state hands the pixel on, so emits do not overlap.
// The first emit after reset or after a configuration write first passes
// through a state that wraps out-of-range output positions, two scale-step
// divisions of one quotient bit per cycle and a shift-add multiply that
// rebuilds the column and row positions.
// At reset all registers hold 256, the load and output positions are zero,
// and the frame store content is undefined until loaded. When the receiver
// stalls, the finished pixel waits in the output register; in_ch stays open
// for a following item, whose result then waits in the output cycle, with
// in_ch closed, until the slot is free.
module bilinear_rgb_image_scaler #(
	parameter int MAX_SOURCE_WIDTH = 256,
	parameter int MAX_SOURCE_HEIGHT = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	brs_in_if.sink    in_ch,
	brs_out_if.source out_ch,
	brs_cfg_if.sink   cfg
);
	localparam int F = FRACTION_BITS;
	localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int SW_W = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int SH_W = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int MAXS = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
		MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
	localparam int CW = $clog2(MAXS);
	localparam int PW = CW + F;
	localparam int IW = brs_pkg::OUT_IDX_W;
	localparam int DW = brs_pkg::CFG_DST_W;
	localparam int TOP_W = 8 + F;
	localparam int V_W = 9 + 2 * F;

	// Configuration registers: the user writes them only while the block is idle.
	logic [brs_pkg::CFG_SRC_W-1:0] source_width_q, source_height_q;
	logic [brs_pkg::CFG_DST_W-1:0] target_width_q, target_height_q;
	logic dirty_q;

	// Clamped sizes as the datapath sees them.
	logic [SW_W-1:0] sw_c;
	logic [SH_W-1:0] sh_c;
	logic [DW-1:0] tw_c, th_c;
	logic [AW:0] total;

	always_comb begin
		if (source_width_q == '0) sw_c = SW_W'(1);
		else if (32'(source_width_q) > MAX_SOURCE_WIDTH) sw_c = SW_W'(MAX_SOURCE_WIDTH);
		else sw_c = SW_W'(source_width_q);
		if (source_height_q == '0) sh_c = SH_W'(1);
		else if (32'(source_height_q) > MAX_SOURCE_HEIGHT) sh_c = SH_W'(MAX_SOURCE_HEIGHT);
		else sh_c = SH_W'(source_height_q);
		if (target_width_q < DW'(2)) tw_c = DW'(2);
		else if (32'(target_width_q) > brs_pkg::TARGET_MAX) tw_c = DW'(brs_pkg::TARGET_MAX);
		else tw_c = target_width_q;
		if (target_height_q < DW'(2)) th_c = DW'(2);
		else if (32'(target_height_q) > brs_pkg::TARGET_MAX) th_c = DW'(brs_pkg::TARGET_MAX);
		else th_c = target_height_q;
		total = (AW+1)'(sw_c) * (AW+1)'(sh_c);
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q <= brs_pkg::CFG_SRC_W'(256);
			source_height_q <= brs_pkg::CFG_SRC_W'(256);
			target_width_q <= brs_pkg::CFG_DST_W'(256);
			target_height_q <= brs_pkg::CFG_DST_W'(256);
		end else if (cfg.valid) begin
			case (cfg.index)
				brs_pkg::REG_SOURCE_WIDTH:  source_width_q <= cfg.data[brs_pkg::CFG_SRC_W-1:0];
				brs_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg.data[brs_pkg::CFG_SRC_W-1:0];
				brs_pkg::REG_TARGET_WIDTH:  target_width_q <= cfg.data;
				brs_pkg::REG_TARGET_HEIGHT: target_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	brs_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;
	logic in_fire;
	logic div_start, div_done;
	logic [PW-1:0] div_num, div_quot;
	logic [DW-1:0] div_den;
	logic [3:0] mul_cnt_q;

	assign in_ch.ready = (state_q == brs_pkg::S_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_num = PW'(sw_c - 1'b1) << F;
		div_den = tw_c - 1'b1;
		case (state_q)
			brs_pkg::S_IDLE: begin
				if (in_fire && in_ch.req_type) state_d = dirty_q ? brs_pkg::S_NORM : brs_pkg::S_LOC;
			end
			brs_pkg::S_NORM: begin
				div_start = 1'b1;
				state_d = brs_pkg::S_DIVX;
			end
			brs_pkg::S_DIVX: begin
				div_num = PW'(sh_c - 1'b1) << F;
				div_den = th_c - 1'b1;
				if (div_done) begin
					div_start = 1'b1;
					state_d = brs_pkg::S_DIVY;
				end
			end
			brs_pkg::S_DIVY: if (div_done) state_d = brs_pkg::S_MUL;
			brs_pkg::S_MUL:  if (mul_cnt_q == '0) state_d = brs_pkg::S_LOC;
			brs_pkg::S_LOC:  state_d = brs_pkg::S_BASE;
			brs_pkg::S_BASE: state_d = brs_pkg::S_RD0;
			brs_pkg::S_RD0:  state_d = brs_pkg::S_RD1;
			brs_pkg::S_RD1:  state_d = brs_pkg::S_RD2;
			brs_pkg::S_RD2:  state_d = brs_pkg::S_RD3;
			brs_pkg::S_RD3:  state_d = brs_pkg::S_RD4;
			brs_pkg::S_RD4:  state_d = brs_pkg::S_BL1;
			brs_pkg::S_BL1:  state_d = brs_pkg::S_BL2;
			brs_pkg::S_BL2:  state_d = brs_pkg::S_OUT;
			brs_pkg::S_OUT:  if (slot_free) state_d = brs_pkg::S_IDLE;
			default: state_d = brs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= brs_pkg::S_IDLE;
		else state_q <= state_d;
	end

	brs_div #(.NW(PW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .done(div_done), .quot(div_quot)
	);

	// Output position and fixed-point positions. The positions follow the
	// indexes by adding the scale step; after a configuration change they are
	// rebuilt by a shift-add multiply.
	logic [IW-1:0] col_q, row_q;
	logic [PW-1:0] step_x_q, step_y_q, pos_x_q, pos_y_q;
	logic [IW:0] col_inc, row_inc, row_norm;

	always_comb begin
		col_inc = {1'b0, col_q} + 1'b1;
		row_inc = {1'b0, row_q} + 1'b1;
		row_norm = ({1'b0, col_q} >= (IW+1)'(tw_c)) ? row_inc : {1'b0, row_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			dirty_q <= 1'b1;
			mul_cnt_q <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else begin
			if (cfg.valid) dirty_q <= 1'b1;
			case (state_q)
				brs_pkg::S_NORM: begin
					if ({1'b0, col_q} >= (IW+1)'(tw_c)) col_q <= '0;
					row_q <= (row_norm >= (IW+1)'(th_c)) ? '0 : row_norm[IW-1:0];
				end
				brs_pkg::S_DIVX: if (div_done) step_x_q <= div_quot;
				brs_pkg::S_DIVY: begin
					if (div_done) begin
						step_y_q <= div_quot;
						pos_x_q <= '0;
						pos_y_q <= '0;
						mul_cnt_q <= 4'(IW - 1);
					end
				end
				brs_pkg::S_MUL: begin
					pos_x_q <= (pos_x_q << 1) + (col_q[mul_cnt_q] ? step_x_q : '0);
					pos_y_q <= (pos_y_q << 1) + (row_q[mul_cnt_q] ? step_y_q : '0);
					mul_cnt_q <= mul_cnt_q - 1'b1;
					if (mul_cnt_q == '0) dirty_q <= 1'b0;
				end
				brs_pkg::S_LOC: begin
					if (col_inc >= (IW+1)'(tw_c)) begin
						col_q <= '0;
						pos_x_q <= '0;
						if (row_inc >= (IW+1)'(th_c)) begin
							row_q <= '0;
							pos_y_q <= '0;
						end else begin
							row_q <= row_inc[IW-1:0];
							pos_y_q <= pos_y_q + step_y_q;
						end
					end else begin
						col_q <= col_inc[IW-1:0];
						pos_x_q <= pos_x_q + step_x_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Locate: neighbor indexes and weights from the current positions.
	logic [CW-1:0] x0_d, x1_d, y0_d, y1_d, sxm1, sym1;
	logic [F-1:0] dx_d, dy_d;
	logic [CW-1:0] x0_s1, x1_s1, y0_s1, y1_s1;
	logic [F-1:0] dx_s1, dy_s1;
	logic last_s1;

	always_comb begin
		sxm1 = CW'(sw_c - 1'b1);
		sym1 = CW'(sh_c - 1'b1);
		if ((DW'(col_q) == tw_c - 1'b1) || (sw_c == SW_W'(1))) begin
			x0_d = sxm1;
			x1_d = sxm1;
			dx_d = '0;
		end else begin
			x0_d = (pos_x_q[PW-1:F] > sxm1) ? sxm1 : pos_x_q[PW-1:F];
			x1_d = (x0_d < sxm1) ? x0_d + 1'b1 : x0_d;
			dx_d = pos_x_q[F-1:0];
		end
		if ((DW'(row_q) == th_c - 1'b1) || (sh_c == SH_W'(1))) begin
			y0_d = sym1;
			y1_d = sym1;
			dy_d = '0;
		end else begin
			y0_d = (pos_y_q[PW-1:F] > sym1) ? sym1 : pos_y_q[PW-1:F];
			y1_d = (y0_d < sym1) ? y0_d + 1'b1 : y0_d;
			dy_d = pos_y_q[F-1:0];
		end
	end

	logic [AW-1:0] base0_s2, base1_s2;

	always_ff @(posedge clk) begin
		if (state_q == brs_pkg::S_LOC) begin
			x0_s1 <= x0_d;
			x1_s1 <= x1_d;
			y0_s1 <= y0_d;
			y1_s1 <= y1_d;
			dx_s1 <= dx_d;
			dy_s1 <= dy_d;
			last_s1 <= (DW'(col_q) == tw_c - 1'b1) && (DW'(row_q) == th_c - 1'b1);
		end
		if (state_q == brs_pkg::S_BASE) begin
			base0_s2 <= AW'(y0_s1) * AW'(sw_c);
			base1_s2 <= AW'(y1_s1) * AW'(sw_c);
		end
	end

	// Frame store: one write port for loads, reads during the fetch states.
	logic [23:0] frame_mem [DEPTH];
	logic [AW-1:0] load_pos_q, load_addr, rd_addr;
	logic [AW:0] load_next;
	logic [23:0] rd_data_q;
	logic rd_en;

	always_comb begin
		load_addr = ({1'b0, load_pos_q} >= total) ? '0 : load_pos_q;
		load_next = {1'b0, load_addr} + 1'b1;
		rd_en = 1'b1;
		case (state_q)
			brs_pkg::S_RD0: rd_addr = base0_s2 + AW'(x0_s1);
			brs_pkg::S_RD1: rd_addr = base0_s2 + AW'(x1_s1);
			brs_pkg::S_RD2: rd_addr = base1_s2 + AW'(x0_s1);
			brs_pkg::S_RD3: rd_addr = base1_s2 + AW'(x1_s1);
			default: begin
				rd_addr = base0_s2;
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) load_pos_q <= '0;
		else if (in_fire && !in_ch.req_type)
			load_pos_q <= (load_next >= total) ? '0 : load_next[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_fire && !in_ch.req_type)
			frame_mem[load_addr] <= {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
		if (rd_en) rd_data_q <= frame_mem[rd_addr];
	end

	// Gather the four neighbors and blend, first across columns, then rows.
	logic [23:0] p00_q, p01_q, p10_q, p11_q;
	logic [TOP_W-1:0] top_s3 [3];
	logic [TOP_W-1:0] bot_s3 [3];
	logic [V_W-1:0] v_s4 [3];
	logic [F:0] wx1, wy1;
	logic [F:0] one_fx;

	assign one_fx = {1'b1, {F{1'b0}}};
	assign wx1 = one_fx - {1'b0, dx_s1};
	assign wy1 = one_fx - {1'b0, dy_s1};

	always_ff @(posedge clk) begin
		case (state_q)
			brs_pkg::S_RD1: p00_q <= rd_data_q;
			brs_pkg::S_RD2: p01_q <= rd_data_q;
			brs_pkg::S_RD3: p10_q <= rd_data_q;
			brs_pkg::S_RD4: p11_q <= rd_data_q;
			default: ;
		endcase
		for (int c = 0; c < 3; c++) begin
			if (state_q == brs_pkg::S_BL1) begin
				top_s3[c] <= TOP_W'(p00_q[c*8 +: 8]) * TOP_W'(wx1)
					+ TOP_W'(p01_q[c*8 +: 8]) * TOP_W'(dx_s1);
				bot_s3[c] <= TOP_W'(p10_q[c*8 +: 8]) * TOP_W'(wx1)
					+ TOP_W'(p11_q[c*8 +: 8]) * TOP_W'(dx_s1);
			end
			if (state_q == brs_pkg::S_BL2)
				v_s4[c] <= V_W'(top_s3[c]) * V_W'(wy1) + V_W'(bot_s3[c]) * V_W'(dy_s1);
		end
	end

	// Round half up and hold the pixel until the receiver takes it.
	logic [V_W-1:0] vr [3];
	logic [7:0] chan [3];
	logic [7:0] red_q, green_q, blue_q;
	logic last_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vr[c] = v_s4[c] + (V_W'(1) << (2 * F - 1));
			chan[c] = (vr[c] >> (2 * F)) > V_W'(255) ? 8'hFF : vr[c][2*F +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == brs_pkg::S_OUT && slot_free) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == brs_pkg::S_OUT && slot_free) begin
			red_q <= chan[0];
			green_q <= chan[1];
			blue_q <= chan[2];
			last_q <= last_s1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.red_out = red_q;
	assign out_ch.green_out = green_q;
	assign out_ch.blue_out = blue_q;
	assign out_ch.pad_byte = 8'h00;
	assign out_ch.last_pixel = last_q;

endmodule

// ===== rtl/core/brs_div.sv =====
// Restoring divider of the scaler, one quotient bit per cycle.
// Depends on nothing.
module brs_div #(
	parameter int NW = 24,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0] work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	logic fits;

	always_comb begin
		rem_sh = {rem_q, work_q[NW-1]};
		fits = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			work_q <= {work_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = work_q;
endmodule

// ===== test/bilinear_rgb_image_scaler_tb.sv =====
// Self-checking testbench for the bilinear RGB image scaler: drives loads,
// emits and register writes, predicts every resized pixel and checks it.
// Depends on brs_pkg, brs_ifs and the bilinear_rgb_image_scaler RTL.
module bilinear_rgb_image_scaler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int STORE_DEPTH = 65536;
	localparam int STALL_LIMIT = 20000;
	// Settle time after a drain: an emit, plus the step divisions and the
	// position rebuild after a register write.
	localparam int SETTLE_CYCLES = 120;

	typedef enum logic {REQ_LOAD = 1'b0, REQ_EMIT = 1'b1} req_e;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] pad;
		logic last;
	} pixel_t;

	// Scoreboard: keeps its own copy of the registers and image state and
	// the queue of resized pixels still owed by the block.
	class scaler_scoreboard;
		logic [23:0] frame[STORE_DEPTH];
		logic [16:0] load_addr;
		int col, row;
		logic [8:0] src_w, src_h;
		logic [10:0] dst_w, dst_h;
		pixel_t owed_pixels[$];
		int errors;

		function void init();
			load_addr = 0; col = 0; row = 0;
			src_w = 256; src_h = 256; dst_w = 256; dst_h = 256;
			owed_pixels.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [brs_pkg::CFG_IDX_W-1:0] idx,
				logic [brs_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				brs_pkg::REG_SOURCE_WIDTH: src_w = val[8:0];
				brs_pkg::REG_SOURCE_HEIGHT: src_h = val[8:0];
				brs_pkg::REG_TARGET_WIDTH: dst_w = val;
				brs_pkg::REG_TARGET_HEIGHT: dst_h = val;
				default: ;
			endcase
		endfunction

		// Left neighbor, right neighbor and right weight for one axis.
		function void axis_map(int idx, int src, int dst, output int i0, output int i1,
				output longint w);
			longint step, pos;
			if (idx == dst - 1 || src == 1) begin
				i0 = src - 1; i1 = src - 1; w = 0;
				return;
			end
			step = (longint'(src - 1) << FRAC) / longint'(dst - 1);
			pos = longint'(idx) * step;
			i0 = int'(pos >> FRAC);
			if (i0 > src - 1) i0 = src - 1;
			i1 = (i0 + 1 < src) ? i0 + 1 : i0;
			w = pos & ((longint'(1) << FRAC) - 1);
		endfunction

		function int clampi(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void note_beat(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int sw, sh, tw, th, total, x0, x1, y0, y1, a;
			longint dx, dy, one, top, bot, v;
			logic [23:0] p00, p01, p10, p11;
			pixel_t px;
			sw = clampi(src_w, 1, 256); sh = clampi(src_h, 1, 256);
			tw = clampi(dst_w, 2, 1024); th = clampi(dst_h, 2, 1024);
			total = sw * sh;
			one = longint'(1) << FRAC;
			if (kind == REQ_LOAD) begin
				if (load_addr >= total) load_addr = 0;
				frame[load_addr] = {b, g, r};
				load_addr++;
				if (load_addr >= total) load_addr = 0;
				return;
			end
			if (col >= tw) begin col = 0; row++; end
			if (row >= th) row = 0;
			axis_map(col, sw, tw, x0, x1, dx);
			axis_map(row, sh, th, y0, y1, dy);
			a = y0 * sw; p00 = frame[a + x0]; p01 = frame[a + x1];
			a = y1 * sw; p10 = frame[a + x0]; p11 = frame[a + x1];
			for (int ch = 0; ch < 3; ch++) begin
				top = longint'(p00[ch*8 +: 8]) * (one - dx) + longint'(p01[ch*8 +: 8]) * dx;
				bot = longint'(p10[ch*8 +: 8]) * (one - dx) + longint'(p11[ch*8 +: 8]) * dx;
				v = (top * (one - dy) + bot * dy + (longint'(1) << (2*FRAC - 1))) >> (2*FRAC);
				if (v > 255) v = 255;
				case (ch)
					0: px.red = v[7:0];
					1: px.green = v[7:0];
					default: px.blue = v[7:0];
				endcase
			end
			px.pad = 8'd0;
			px.last = (col == tw - 1 && row == th - 1);
			col++;
			if (col >= tw) begin
				col = 0; row++;
				if (row >= th) row = 0;
			end
			owed_pixels.push_back(px);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t exp_px;
			if (owed_pixels.size() == 0) begin
				$display("%0t: unexpected pixel beat, got %h", $time, got);
				errors++;
				return;
			end
			exp_px = owed_pixels.pop_front();
			if (got.red !== exp_px.red)
				$display("%0t: red expected %h actual %h", $time, exp_px.red, got.red);
			if (got.green !== exp_px.green)
				$display("%0t: green expected %h actual %h", $time, exp_px.green, got.green);
			if (got.blue !== exp_px.blue)
				$display("%0t: blue expected %h actual %h", $time, exp_px.blue, got.blue);
			if (got.pad !== exp_px.pad)
				$display("%0t: pad expected %h actual %h", $time, exp_px.pad, got.pad);
			if (got.last !== exp_px.last)
				$display("%0t: last expected %b actual %b", $time, exp_px.last, got.last);
			if (got !== exp_px) errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	brs_in_if in_ch();
	brs_out_if out_ch();
	brs_cfg_if cfg();

	bilinear_rgb_image_scaler DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	scaler_scoreboard board;
	int idle_pct = 22;       // Both sides idle this often unless set to zero.
	bit hold_output = 0;     // Set while the receiver is held off on purpose.
	int quiet_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Idle inputs are driven known from time zero.
	initial begin
		in_ch.valid = 1'b0; in_ch.req_type = 1'b0;
		in_ch.red_in = 8'd0; in_ch.green_in = 8'd0; in_ch.blue_in = 8'd0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		out_ch.ready = 1'b0;
	end

	// The receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_pixel({out_ch.red_out, out_ch.green_out, out_ch.blue_out,
				out_ch.pad_byte, out_ch.last_pixel});
		out_ch.ready <= arst_n && !hold_output && ($urandom_range(99) >= idle_pct);
	end

	// The watchdog counts cycles in which no beat crosses any channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one request beat, with a random idle gap first, and wait for it.
	// Valid stays high after the beat; the next gap or a drain drops it.
	task automatic send_beat(req_e kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.req_type <= kind;
		in_ch.red_in <= r; in_ch.green_in <= g; in_ch.blue_in <= b;
		do @(posedge clk); while (!in_ch.ready);
		board.note_beat(kind, r, g, b);
	endtask

	task automatic send_load_rand();
		send_beat(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Stop offering, wait for every owed pixel, then let the block settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.owed_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [brs_pkg::CFG_IDX_W-1:0] idx,
			logic [brs_pkg::CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, val);
	endtask

	// Write all four sizes once the block is empty.
	task automatic set_regs(int sw, int sh, int tw, int th);
		drain();
		write_reg(brs_pkg::REG_SOURCE_WIDTH, sw);
		write_reg(brs_pkg::REG_SOURCE_HEIGHT, sh);
		write_reg(brs_pkg::REG_TARGET_WIDTH, tw);
		write_reg(brs_pkg::REG_TARGET_HEIGHT, th);
		cfg.valid <= 1'b0;
	endtask

	// Set all four sizes and fill one complete source frame, so every later
	// read hits a written frame-store entry.
	task automatic set_sizes(int sw, int sh, int tw, int th);
		set_regs(sw, sh, tw, th);
		// A shrink may leave the load pointer anywhere; a full frame from any
		// start still covers every entry of the new frame.
		repeat (sw * sh) send_load_rand();
	endtask

	task automatic emit_n(int n);
		repeat (n) send_beat(REQ_EMIT, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int sw, sh, tw, th;
		board = new();
		board.init();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 2x2 source with extreme bytes, upscaled to 3x3 so the
		// middle pixel is a true four-way blend and the corners copy source corners.
		set_sizes(2, 2, 3, 3);
		drain();
		// Reload the frame with chosen corner values.
		send_beat(REQ_LOAD, 8'hFF, 8'h00, 8'hAA);
		send_beat(REQ_LOAD, 8'h00, 8'hFF, 8'h55);
		send_beat(REQ_LOAD, 8'h01, 8'hFE, 8'h80);
		send_beat(REQ_LOAD, 8'h7F, 8'h80, 8'hFF);
		emit_n(9);
		// One-pixel-wide and one-pixel-high sources copy their edge.
		set_sizes(1, 3, 2, 4);
		emit_n(8);
		set_sizes(3, 1, 5, 2);
		emit_n(5);

		// Largest target sizes with the smallest source: only part of the first row.
		set_sizes(1, 1, 1024, 1024);
		emit_n(40);
		// Out-of-range writes: zero sizes clamp to 1 and 2, and only the first
		// entries, already loaded, are read.
		set_regs(0, 0, 0, 1);
		emit_n(6);
		// Width clamps to 256, height 513 masks to 1, target width clamps.
		set_regs(511, 513, 2047, 2);
		emit_n(4);

		// Long receiver hold-off while requests keep coming, so the block fills.
		set_sizes(4, 3, 7, 5);
		hold_output = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_output = 0;
			end
			emit_n(12);
		join

		// Random phases: mostly well-formed frame-then-emit sequences.
		for (int phase = 0; phase < 8; phase++) begin
			sw = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 6);
			sh = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 6);
			tw = $urandom_range(2, 12);
			th = $urandom_range(2, 12);
			if (phase == 3) begin sw = 32; sh = 1; end
			if (phase == 5) begin sw = 1; sh = 32; end
			if (phase == 4) idle_pct = 0;
			if (phase == 7) idle_pct = 22;
			set_sizes(sw, sh, tw, th);
			for (int k = 0; k < 20; k++) begin
				// Occasional extra loads overwrite the frame with new content.
				if ($urandom_range(9) == 0) send_load_rand();
				else emit_n(1);
			end
			// Sender pause: every owed pixel comes back before going on.
			if (phase == 4) drain();
		end

		// Full-size default-like frame: 256 x 256 is too slow to load, so
		// only smaller wide and tall sources are exercised above.
		drain();
		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// The sender's valid stays high between back-to-back beats and is only
	// dropped in an idle gap or before a drain, and the write channel's valid
	// only after its last write, so no signal gets two nonblocking writes in
	// one step.
endmodule

// ===== bilinear_rgb_image_scaler.f =====
rtl/core/brs_pkg.sv
rtl/core/brs_ifs.sv
rtl/core/brs_div.sv
rtl/core/bilinear_rgb_image_scaler.sv
test/bilinear_rgb_image_scaler_tb.sv
